@@ rtl/tsr_pkg.sv @@
// tsr_pkg: shared types and constants of the stream reassembler
// used by the controller, the datapath and the top level; no dependencies
package tsr_pkg;

  localparam int unsigned TSR_DEPTH_DEF = 1024;
  localparam logic [10:0] TSR_WCAP_RST  = 11'd1024;
  localparam logic [2:0]  TSR_REG_WCAP  = 3'd0;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_RD,
    ST_RD_DATA,
    ST_FIN
  } tsr_state_t;

  typedef struct packed {
    logic clr_step;
    logic latch;
    logic pres_rd_push;
    logic push_wr;
    logic walk_take;
    logic rd_take;
    logic fin_load;
  } tsr_cmd_t;

  typedef struct packed {
    logic req_rd;
    logic in_win;
    logic asm_pend;
    logic walk_ok;
    logic walk_ok_next;
    logic present;
    logic clr_last;
    logic out_free;
  } tsr_sts_t;

endpackage

@@ rtl/tsr_ram.sv @@
// tsr_ram: generic single-write, single-read ram with registered read data
// no dependencies
module tsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tsr_ctrl.sv @@
// tsr_ctrl: sequencer for clear sweep, push, assembly walk and read
// depends on tsr_pkg
module tsr_ctrl
  import tsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  tsr_sts_t sts,
  output logic     in_ready,
  output tsr_cmd_t cmd
);

  tsr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.latch  = 1'b1;
          state_next = ST_PUSH_RD;
        end
      end
      ST_PUSH_RD: begin
        if (sts.req_rd) begin
          state_next = ST_RD;
        end else if (sts.in_win) begin
          cmd.pres_rd_push = 1'b1;
          state_next       = ST_PUSH_WR;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_PUSH_WR: begin
        cmd.push_wr = 1'b1;
        state_next  = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        state_next = sts.walk_ok ? ST_WALK_CHK : ST_FIN;
      end
      ST_WALK_CHK: begin
        if (sts.present) begin
          cmd.walk_take = 1'b1;
          if (!sts.walk_ok_next) state_next = ST_FIN;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_RD: begin
        state_next = sts.asm_pend ? ST_RD_DATA : ST_FIN;
      end
      ST_RD_DATA: begin
        cmd.rd_take = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.fin_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/tsr_dp.sv @@
// tsr_dp: positions, counters, byte ring, presence ram and result register
// depends on tsr_pkg and tsr_ram
module tsr_dp
  import tsr_pkg::*;
#(
  parameter int unsigned DEPTH = TSR_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  tsr_cmd_t    cmd,
  output tsr_sts_t    sts,
  input  logic [10:0] wcap,
  input  logic        in_req,
  input  logic [31:0] in_idx,
  input  logic [7:0]  in_data,
  input  logic        in_last,
  input  logic        in_eof,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [55:0] out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [31:0] DEPTH_32 = 32'(DEPTH);

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    wrap = (s >= DEPTH_W) ? AW'(s - DEPTH_W) : s[AW-1:0];
  endfunction

  logic          req_q, acc_q, rvalid_q;
  logic [31:0]   idx_q, rd_pos, asm_pos, eof_pos;
  logic [7:0]    data_q, rbyte_q;
  logic [CW-1:0] held;
  logic          eof_seen, ended, ended_next;
  logic [AW-1:0] head, clr_cnt;
  logic [31:0]   cap32, off, aoff, eoff, eof_rel;
  logic [AW-1:0] push_slot, walk_slot, walk_next;
  logic          pres_we, pres_wd, pres_rd;
  logic [AW-1:0] pres_wa, pres_ra;
  logic [7:0]    ring_rd;

  assign cap32     = (32'(wcap) > DEPTH_32) ? DEPTH_32 : 32'(wcap);
  assign off       = idx_q - rd_pos;
  assign aoff      = asm_pos - rd_pos;
  assign push_slot = wrap({1'b0, head} + off[AW:0]);
  assign walk_slot = wrap({1'b0, head} + aoff[AW:0]);
  assign walk_next = wrap({1'b0, head} + aoff[AW:0] + (AW + 1)'(1));
  assign eoff      = (in_idx + 32'd1) - rd_pos;
  assign eof_rel   = eof_pos - rd_pos;
  assign ended_next = ended || (eof_seen && (eof_rel <= aoff));

  always_comb begin
    pres_we = 1'b0;
    pres_wa = walk_slot;
    pres_wd = 1'b0;
    if (cmd.clr_step) begin
      pres_we = 1'b1;
      pres_wa = clr_cnt;
    end else if (cmd.push_wr) begin
      pres_we = 1'b1;
      pres_wa = push_slot;
      pres_wd = 1'b1;
    end else if (cmd.walk_take) begin
      pres_we = 1'b1;
    end
    if (cmd.pres_rd_push) pres_ra = push_slot;
    else if (cmd.walk_take) pres_ra = walk_next;
    else pres_ra = walk_slot;
  end

  tsr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_pres (
    .clk(clk), .we(pres_we), .waddr(pres_wa), .wdata(pres_wd),
    .raddr(pres_ra), .rdata(pres_rd)
  );

  tsr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ring (
    .clk(clk), .we(cmd.push_wr), .waddr(push_slot), .wdata(data_q),
    .raddr(head), .rdata(ring_rd)
  );

  always_comb begin
    sts.req_rd       = req_q;
    sts.in_win       = (off >= aoff) && (off < cap32);
    sts.asm_pend     = rd_pos != asm_pos;
    sts.walk_ok      = aoff < DEPTH_32;
    sts.walk_ok_next = (aoff + 32'd1) < DEPTH_32;
    sts.present      = pres_rd;
    sts.clr_last     = clr_cnt == AW'(DEPTH - 1);
    sts.out_free     = !out_valid || out_ready;
  end

  // item latch and result flags
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q    <= in_req;
      idx_q    <= in_idx;
      data_q   <= in_data;
      acc_q    <= 1'b0;
      rvalid_q <= 1'b0;
      rbyte_q  <= 8'd0;
    end
    if (cmd.push_wr) acc_q <= 1'b1;
    if (cmd.rd_take) begin
      rvalid_q <= 1'b1;
      rbyte_q  <= ring_rd;
    end
    if (cmd.fin_load) begin
      out_data <= {2'b00, ended_next, asm_pos, 11'(held), acc_q, rvalid_q, rbyte_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pos    <= '0;
      asm_pos   <= '0;
      held      <= '0;
      eof_seen  <= 1'b0;
      eof_pos   <= '0;
      ended     <= 1'b0;
      head      <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.latch && !in_req && in_last && in_eof && !eof_seen && (eoff <= cap32)) begin
        eof_seen <= 1'b1;
        eof_pos  <= in_idx + 32'd1;
      end
      if (cmd.push_wr && !pres_rd) held <= held + CW'(1);
      if (cmd.walk_take) begin
        asm_pos <= asm_pos + 32'd1;
        if (held != '0) held <= held - CW'(1);
      end
      if (cmd.rd_take) begin
        rd_pos <= rd_pos + 32'd1;
        head   <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      end
      if (cmd.fin_load) begin
        out_valid <= 1'b1;
        ended     <= ended_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(DEPTH)) else $error("held count beyond ring depth");
  a_asm_ahead: assert property (@(posedge clk) disable iff (rst)
    aoff <= DEPTH_32) else $error("assembled position runs past ring");
  a_ended_sticky: assert property (@(posedge clk) disable iff (rst)
    ended |=> ended) else $error("stream end dropped");
  a_eof_hold: assert property (@(posedge clk) disable iff (rst)
    eof_seen |=> eof_seen && eof_pos == $past(eof_pos)) else $error("eof moved");

endmodule

@@ rtl/tcp_stream_reassembler_unit.sv @@
// tcp_stream_reassembler_unit: top level of the out-of-order byte reassembler
// depends on tsr_pkg, tsr_ctrl, tsr_dp (and tsr_ram inside tsr_dp)
//
//  channel  | signals                            | payload
//  ---------+------------------------------------+---------------------------------
//  s_axis   | s_tvalid s_tready s_tdata s_tlast  | push/read request, one item
//           | s_tuser                            |
//  m_axis   | m_tvalid m_tready m_tdata          | one result item per request
//  apb      | psel penable pwrite paddr pwdata   | window_capacity at address 0
//           | prdata pready                      |
//
// after reset the presence ram is swept clear, one slot after another, no item taken
// per accepted item: a read takes the byte at the ring head if one is assembled,
// a push is dropped outside the window, else its byte is written and the walk runs
// the assembly walk steps one ring slot a cycle through the presence ram port
// a result waits in the output register; the next item is taken meanwhile
// reset is synchronous, active high
module tcp_stream_reassembler_unit
  import tsr_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = TSR_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // stream_index[31:0], data_byte[39:32]
  input  logic        s_tlast,   // segment_last
  input  logic [1:0]  s_tuser,   // req_type[0], eof_flag[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_byte[7:0], read_valid[8], byte_accepted[9], unassembled_count[20:10],
  // assembled_total[52:21], stream_ended[53], zero[55:54]
  output logic [55:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tsr_cmd_t    cmd;
  tsr_sts_t    sts;
  logic [10:0] wcap;
  logic        in_fire;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == TSR_REG_WCAP) ? {21'd0, wcap} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wcap <= TSR_WCAP_RST;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      wcap <= pwdata[10:0];
    end
  end

  assign in_fire = s_tvalid && s_tready;

  tsr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .sts(sts),
    .in_ready(s_tready), .cmd(cmd)
  );

  tsr_dp #(.DEPTH(BUFFER_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .wcap(wcap),
    .in_req(s_tuser[0]), .in_idx(s_tdata[31:0]), .in_data(s_tdata[39:32]),
    .in_last(s_tlast), .in_eof(s_tuser[1]),
    .out_ready(m_tready), .out_valid(m_tvalid), .out_data(m_tdata)
  );

endmodule
